// ===== src/nand_read_remap_splitter_core_assert.svh =====
// Assertion helpers for the RTL, included by nrrs_back
`ifndef NAND_READ_REMAP_SPLITTER_CORE_ASSERT_SVH
`define NAND_READ_REMAP_SPLITTER_CORE_ASSERT_SVH

// same-cycle implication
`define NRRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("nrrs assertion failed");

// next-cycle implication
`define NRRS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("nrrs assertion failed");

`endif

// ===== src/nrrs_pkg.sv =====
`default_nettype none
package nrrs_pkg;

    localparam int LOGICAL_BLOCKS = 32;
    localparam int BURST_BYTES    = 256;
    localparam int MAX_COUNT      = 4096;
    localparam int QUEUE_DEPTH    = 2;

    localparam int ACT_W     = 2;
    localparam int ADDR_W    = 32;
    localparam int COUNT_W   = 13;
    localparam int TIDX_W    = 5;
    localparam int TVAL_W    = 12;
    localparam int ROW_W     = 24;
    localparam int COL_W     = 16;
    localparam int LEN_W     = 9;
    localparam int OFF_W     = 12;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 1;
    localparam int LBLK_W    = $clog2(LOGICAL_BLOCKS);
    localparam int PSIZE_W   = 14;

    localparam logic [CFG_W-1:0] PSL_MIN = 4'd9;
    localparam logic [CFG_W-1:0] PSL_MAX = 4'd13;
    localparam logic [CFG_W-1:0] PSL_RST = 4'd11;
    localparam logic [CFG_W-1:0] PBL_MIN = 4'd4;
    localparam logic [CFG_W-1:0] PBL_MAX = 4'd8;
    localparam logic [CFG_W-1:0] PBL_RST = 4'd6;

    typedef enum logic [ACT_W-1:0] {
        ACT_READ   = 2'd0,
        ACT_TABLE  = 2'd1,
        ACT_INVAL  = 2'd2,
        ACT_UNUSED = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        CMD_READ,
        CMD_TABLE,
        CMD_INVAL
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAGE_SIZE       = 1'b0,
        CFG_PAGES_PER_BLOCK = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAGE,
        ST_BURST
    } t_state;

    typedef struct packed {
        t_cmd                cmd;
        logic [ADDR_W-1:0]   addr;
        logic [COUNT_W-1:0]  count;
        logic [TIDX_W-1:0]   tidx;
        logic [TVAL_W-1:0]   tval;
    } t_cmd_word;

    // clamped flash geometry
    typedef struct packed {
        logic [CFG_W-1:0] psl;
        logic [CFG_W-1:0] pbl;
    } t_geom;

endpackage
`default_nettype wire

// ===== src/nrrs_front.sv =====
`default_nettype none
module nrrs_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [nrrs_pkg::ACT_W-1:0]       i_action,
    input  logic [nrrs_pkg::ADDR_W-1:0]      i_byte_address,
    input  logic [nrrs_pkg::COUNT_W-1:0]     i_byte_count,
    input  logic [nrrs_pkg::TIDX_W-1:0]      i_table_index,
    input  logic [nrrs_pkg::TVAL_W-1:0]      i_table_value,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [nrrs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [nrrs_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                             i_q_full,
    output logic                             o_push,
    output nrrs_pkg::t_cmd_word              o_push_word,
    output nrrs_pkg::t_geom                  o_geom
);
    import nrrs_pkg::*;

    logic [CFG_W-1:0]   r_psl;
    logic [CFG_W-1:0]   r_pbl;
    logic               keep;
    logic               in_table;
    logic [COUNT_W-1:0] count_sat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_psl <= PSL_RST;
            r_pbl <= PBL_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_PAGE_SIZE:       r_psl <= i_cfg_data;
                CFG_PAGES_PER_BLOCK: r_pbl <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        o_geom.psl = (r_psl < PSL_MIN) ? PSL_MIN : ((r_psl > PSL_MAX) ? PSL_MAX : r_psl);
        o_geom.pbl = (r_pbl < PBL_MIN) ? PBL_MIN : ((r_pbl > PBL_MAX) ? PBL_MAX : r_pbl);
    end

    assign o_ready   = !i_q_full;
    assign in_table  = (int'(i_table_index) < LOGICAL_BLOCKS);
    assign count_sat = (i_byte_count > COUNT_W'(MAX_COUNT)) ? COUNT_W'(MAX_COUNT)
                                                            : i_byte_count;

    // sort words; unused codes and out-of-table writes are dropped here
    always_comb begin
        keep            = 1'b0;
        o_push_word.cmd = CMD_READ;
        unique case (t_action'(i_action))
            ACT_READ: begin
                keep            = 1'b1;
                o_push_word.cmd = CMD_READ;
            end
            ACT_TABLE: begin
                keep            = in_table;
                o_push_word.cmd = CMD_TABLE;
            end
            ACT_INVAL: begin
                keep            = 1'b1;
                o_push_word.cmd = CMD_INVAL;
            end
            ACT_UNUSED: begin
                keep = 1'b0;
            end
            default: ;
        endcase
        o_push_word.addr  = i_byte_address;
        o_push_word.count = count_sat;
        o_push_word.tidx  = i_table_index;
        o_push_word.tval  = i_table_value;
    end

    assign o_push = i_valid && o_ready && keep;

endmodule
`default_nettype wire

// ===== src/nrrs_queue.sv =====
`default_nettype none
module nrrs_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  nrrs_pkg::t_cmd_word i_word,
    output logic                o_full,
    output logic                o_valid,
    output nrrs_pkg::t_cmd_word o_head,
    input  logic                i_pop
);
    import nrrs_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd_word        r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

// ===== src/nrrs_back.sv =====
`default_nettype none
`include "nand_read_remap_splitter_core_assert.svh"
module nrrs_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_q_valid,
    input  nrrs_pkg::t_cmd_word              i_q_word,
    output logic                             o_pop,
    input  nrrs_pkg::t_geom                  i_geom,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_load_page,
    output logic [nrrs_pkg::ROW_W-1:0]       o_row_address,
    output logic [nrrs_pkg::COL_W-1:0]       o_column_address,
    output logic [nrrs_pkg::LEN_W-1:0]       o_burst_length,
    output logic [nrrs_pkg::OFF_W-1:0]       o_destination_offset,
    output logic                             o_last,
    output logic                             o_range_error
);
    import nrrs_pkg::*;

    t_state              r_state, n_state;
    logic [TVAL_W-1:0]   r_table [LOGICAL_BLOCKS];
    logic                r_cache_valid;
    logic [ROW_W-1:0]    r_cache_row;
    logic [ADDR_W-1:0]   r_addr;
    logic [COUNT_W-1:0]  r_count;
    logic [COUNT_W-1:0]  r_done;
    logic [COUNT_W-1:0]  r_left;
    logic [COL_W-1:0]    r_col;
    logic [ROW_W-1:0]    r_prow;
    logic                r_load;

    logic                r_out_valid;
    logic                r_out_load;
    logic [ROW_W-1:0]    r_out_row;
    logic [COL_W-1:0]    r_out_col;
    logic [LEN_W-1:0]    r_out_len;
    logic [OFF_W-1:0]    r_out_off;
    logic                r_out_last;
    logic                r_out_err;

    logic                slot_free;
    logic                take;
    logic                start_read;
    logic                emit_err;
    logic                emit_burst;
    logic                page_ok;

    // page decode
    logic [PSIZE_W-1:0]  psize;
    logic [COUNT_W-1:0]  col_in;
    logic [PSIZE_W-1:0]  part;
    logic [COUNT_W-1:0]  rem;
    logic [COUNT_W-1:0]  part_cl;
    logic [ADDR_W-1:0]   lrow;
    logic [ADDR_W-1:0]   lblock;
    logic                in_range;
    logic [TVAL_W-1:0]   pblock;
    logic [ROW_W-1:0]    page_mask;
    logic [ROW_W-1:0]    prow;
    logic [COL_W-1:0]    col_full;
    logic                need_load;

    // burst decode
    logic [LEN_W-1:0]    len;
    logic [COUNT_W-1:0]  done_nxt;
    logic                fin;
    logic                page_end;

    assign slot_free = !r_out_valid || i_ready;

    always_comb begin
        psize     = PSIZE_W'(1) << i_geom.psl;
        col_in    = r_addr[COUNT_W-1:0] & COUNT_W'(psize - PSIZE_W'(1));
        part      = psize - PSIZE_W'(col_in);
        rem       = r_count - r_done;
        part_cl   = (part > PSIZE_W'(rem)) ? rem : part[COUNT_W-1:0];
        lrow      = r_addr >> i_geom.psl;
        lblock    = lrow >> i_geom.pbl;
        in_range  = (lblock < ADDR_W'(LOGICAL_BLOCKS));
        pblock    = r_table[lblock[LBLK_W-1:0]];
        page_mask = (ROW_W'(1) << i_geom.pbl) - ROW_W'(1);
        prow      = (ROW_W'(pblock) << i_geom.pbl) | (lrow[ROW_W-1:0] & page_mask);
        // odd physical block sits on the other plane
        col_full  = COL_W'(col_in) | (pblock[0] ? (COL_W'(psize) << 1) : '0);
        need_load = !r_cache_valid || (r_cache_row != prow);
    end

    always_comb begin
        len      = (r_left > COUNT_W'(BURST_BYTES)) ? LEN_W'(BURST_BYTES)
                                                    : r_left[LEN_W-1:0];
        done_nxt = r_done + COUNT_W'(len);
        fin      = (done_nxt >= r_count);
        page_end = (r_left == COUNT_W'(len));
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid && (i_q_word.cmd == CMD_READ) && (i_q_word.count != '0)) begin
                    n_state = ST_PAGE;
                end
            end
            ST_PAGE: begin
                if (in_range) begin
                    n_state = ST_BURST;
                end else if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_BURST: begin
                if (slot_free && page_end) begin
                    n_state = fin ? ST_IDLE : ST_PAGE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        take       = 1'b0;
        start_read = 1'b0;
        emit_err   = 1'b0;
        emit_burst = 1'b0;
        page_ok    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                take       = i_q_valid;
                start_read = i_q_valid && (i_q_word.cmd == CMD_READ);
            end
            ST_PAGE: begin
                page_ok  = in_range;
                emit_err = !in_range && slot_free;
            end
            ST_BURST: begin
                emit_burst = slot_free;
            end
            default: ;
        endcase
    end

    assign o_pop = take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_cache_valid <= 1'b0;
            r_cache_row   <= '0;
            r_out_valid   <= 1'b0;
            for (int i = 0; i < LOGICAL_BLOCKS; i++) begin
                r_table[i] <= TVAL_W'(i);
            end
        end else begin
            r_state <= n_state;
            if (take && (i_q_word.cmd == CMD_TABLE)) begin
                r_table[i_q_word.tidx[LBLK_W-1:0]] <= i_q_word.tval;
            end
            if (take && (i_q_word.cmd == CMD_INVAL)) begin
                r_cache_valid <= 1'b0;
            end else if (page_ok) begin
                r_cache_valid <= 1'b1;
                r_cache_row   <= prow;
            end
            if (emit_err || emit_burst) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_read) begin
            r_addr  <= i_q_word.addr;
            r_count <= i_q_word.count;
            r_done  <= '0;
        end
        if (page_ok) begin
            r_prow <= prow;
            r_col  <= col_full;
            r_load <= need_load;
            r_left <= part_cl;
            r_addr <= r_addr + ADDR_W'(part_cl);
        end
        if (emit_burst) begin
            r_load <= 1'b0;
            r_col  <= r_col + COL_W'(len);
            r_done <= done_nxt;
            r_left <= r_left - COUNT_W'(len);
        end
        if (emit_err) begin
            r_out_load <= 1'b0;
            r_out_row  <= '0;
            r_out_col  <= '0;
            r_out_len  <= '0;
            r_out_off  <= r_done[OFF_W-1:0];
            r_out_last <= 1'b1;
            r_out_err  <= 1'b1;
        end else if (emit_burst) begin
            r_out_load <= r_load;
            r_out_row  <= r_prow;
            r_out_col  <= r_col;
            r_out_len  <= len;
            r_out_off  <= r_done[OFF_W-1:0];
            r_out_last <= fin;
            r_out_err  <= 1'b0;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_load_page          = r_out_load;
    assign o_row_address        = r_out_row;
    assign o_column_address     = r_out_col;
    assign o_burst_length       = r_out_len;
    assign o_destination_offset = r_out_off;
    assign o_last               = r_out_last;
    assign o_range_error        = r_out_err;

    `NRRS_ASSERT_IMP(a_err_word_shape, i_clk, i_rst_n, r_out_valid && r_out_err,
        r_out_last && (r_out_len == '0) && !r_out_load)
    `NRRS_ASSERT_IMP(a_burst_has_bytes, i_clk, i_rst_n, r_state == ST_BURST,
        (r_left != '0) && (r_done < r_count))
    `NRRS_ASSERT_NXT(a_last_burst_ends, i_clk, i_rst_n, emit_burst && fin && page_end,
        (r_state == ST_IDLE) && r_out_valid && r_out_last)
    `NRRS_ASSERT_IMP(a_pop_only_idle, i_clk, i_rst_n, r_state != ST_IDLE, !o_pop)

endmodule
`default_nettype wire

// ===== src/nand_read_remap_splitter_core.sv =====
`default_nettype none
// NAND read splitter with bad-block remap. Each input word is a read request
// (byte address, count), a remap table write or a cache-mark invalidate. Reads
// are cut at page boundaries, remapped through a 32-entry block table (identity
// after reset) and cut again into bursts of up to 256 bytes, one output word per
// burst. Words pass through a two-entry queue into a single sequencer, which
// takes a word, then for each page does the lookup and row build and then emits
// that page's bursts; table writes and invalidates end at the take, and a held
// output stalls the bursts. The user must write page size and pages per block
// on the config port only while the block is idle; the block itself does not
// enforce it. Out-of-range values are clamped.
module nand_read_remap_splitter_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [nrrs_pkg::ACT_W-1:0]       i_action,
    input  logic [nrrs_pkg::ADDR_W-1:0]      i_byte_address,
    input  logic [nrrs_pkg::COUNT_W-1:0]     i_byte_count,
    input  logic [nrrs_pkg::TIDX_W-1:0]      i_table_index,
    input  logic [nrrs_pkg::TVAL_W-1:0]      i_table_value,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_load_page,
    output logic [nrrs_pkg::ROW_W-1:0]       o_row_address,
    output logic [nrrs_pkg::COL_W-1:0]       o_column_address,
    output logic [nrrs_pkg::LEN_W-1:0]       o_burst_length,
    output logic [nrrs_pkg::OFF_W-1:0]       o_destination_offset,
    output logic                             o_last,
    output logic                             o_range_error,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [nrrs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [nrrs_pkg::CFG_W-1:0]       i_cfg_data
);
    import nrrs_pkg::*;

    logic      q_full;
    logic      q_valid;
    logic      push;
    logic      pop;
    t_cmd_word push_word;
    t_cmd_word head_word;
    t_geom     geom;

    nrrs_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_action       (i_action),
        .i_byte_address (i_byte_address),
        .i_byte_count   (i_byte_count),
        .i_table_index  (i_table_index),
        .i_table_value  (i_table_value),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_push_word    (push_word),
        .o_geom         (geom)
    );

    nrrs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (push_word),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head_word),
        .i_pop   (pop)
    );

    nrrs_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_q_valid            (q_valid),
        .i_q_word             (head_word),
        .o_pop                (pop),
        .i_geom               (geom),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_load_page          (o_load_page),
        .o_row_address        (o_row_address),
        .o_column_address     (o_column_address),
        .o_burst_length       (o_burst_length),
        .o_destination_offset (o_destination_offset),
        .o_last               (o_last),
        .o_range_error        (o_range_error)
    );

endmodule
`default_nettype wire

// ===== tb/sv/nrrs_tb_pkg.sv =====
`timescale 1ns / 1ps
package nrrs_tb_pkg;
    import nrrs_pkg::*;

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic             load_page;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [LEN_W-1:0] len;
        logic [OFF_W-1:0] offset;
        logic             last;
        logic             range_err;
    } t_burst_cmd;

    // Tracks remap table, cache mark and geometry; turns each accepted word into
    // the burst commands it should produce.
    class burst_scoreboard;
        logic [TVAL_W-1:0] remap [LOGICAL_BLOCKS];
        bit                cache_valid;
        logic [ROW_W-1:0]  cache_row;
        logic [CFG_W-1:0]  page_size_reg;
        logic [CFG_W-1:0]  block_size_reg;
        t_burst_cmd        pending_bursts [$];
        int unsigned       mismatches;

        function new();
            for (int i = 0; i < LOGICAL_BLOCKS; i++) begin
                remap[i] = i[TVAL_W-1:0];
            end
            cache_valid    = 1'b0;
            cache_row      = '0;
            page_size_reg  = PSL_RST;
            block_size_reg = PBL_RST;
            mismatches     = 0;
        endfunction

        function int unsigned outstanding();
            return pending_bursts.size();
        endfunction

        // register values outside the legal range are clamped when used
        function void effective_shifts(input logic [CFG_W-1:0] ps_raw,
                                       input logic [CFG_W-1:0] bs_raw,
                                       output int unsigned ps, output int unsigned bs);
            ps = 32'((ps_raw < PSL_MIN) ? PSL_MIN : (ps_raw > PSL_MAX) ? PSL_MAX : ps_raw);
            bs = 32'((bs_raw < PBL_MIN) ? PBL_MIN : (bs_raw > PBL_MAX) ? PBL_MAX : bs_raw);
        endfunction

        function void write_reg(t_cfg_reg idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_PAGE_SIZE:       page_size_reg  = data;
                CFG_PAGES_PER_BLOCK: block_size_reg = data;
                default: ;
            endcase
        endfunction

        function void add_burst(logic load, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                                logic [LEN_W-1:0] len, logic [OFF_W-1:0] offset,
                                logic last, logic range_err);
            t_burst_cmd b;
            b.load_page = load;
            b.row       = row;
            b.col       = col;
            b.len       = len;
            b.offset    = offset;
            b.last      = last;
            b.range_err = range_err;
            pending_bursts.push_back(b);
        endfunction

        function void note_word(t_action act, logic [ADDR_W-1:0] addr,
                                logic [COUNT_W-1:0] count, logic [TIDX_W-1:0] tidx,
                                logic [TVAL_W-1:0] tval);
            int unsigned ps, bs;
            logic [31:0] psize, total, done, part, left, len, col, lrow, lblock, row32;
            logic [ADDR_W-1:0] cur;
            logic [TVAL_W-1:0] pblock;
            logic [ROW_W-1:0]  prow;
            logic              load;
            case (act)
                ACT_TABLE: remap[tidx] = tval;
                ACT_INVAL: cache_valid = 1'b0;
                ACT_READ: begin
                    effective_shifts(page_size_reg, block_size_reg, ps, bs);
                    psize = 32'd1 << ps;
                    total = (count > MAX_COUNT) ? MAX_COUNT : {19'd0, count};
                    cur   = addr;
                    done  = '0;
                    while (done < total) begin
                        lrow   = cur >> ps;
                        col    = cur & (psize - 32'd1);
                        part   = psize - col;
                        if (part > total - done)
                            part = total - done;
                        lblock = lrow >> bs;
                        if (lblock >= LOGICAL_BLOCKS) begin
                            // rest of the request abandoned, cache mark untouched
                            add_burst(1'b0, '0, '0, '0, done[OFF_W-1:0], 1'b1, 1'b1);
                            return;
                        end
                        pblock = remap[lblock[LBLK_W-1:0]];
                        row32  = ({20'd0, pblock} << bs) | (lrow & ((32'd1 << bs) - 32'd1));
                        prow   = row32[ROW_W-1:0];
                        if (pblock[0])
                            col = col | (psize << 1);
                        load        = !cache_valid || cache_row != prow;
                        cache_row   = prow;
                        cache_valid = 1'b1;
                        left = part;
                        while (left > 0) begin
                            len = (left > BURST_BYTES) ? BURST_BYTES : left;
                            add_burst(load, prow, col[COL_W-1:0], len[LEN_W-1:0],
                                      done[OFF_W-1:0], (done + len) >= total, 1'b0);
                            load = 1'b0;
                            col  = col + len;
                            done = done + len;
                            left = left - len;
                        end
                        cur = cur + part;
                    end
                end
                default: ;
            endcase
        endfunction

        function string describe(t_burst_cmd b);
            return $sformatf("load=%0d row=%06h col=%04h len=%0d off=%0d last=%0d err=%0d",
                             b.load_page, b.row, b.col, b.len, b.offset, b.last,
                             b.range_err);
        endfunction

        function void check_burst(t_burst_cmd got);
            t_burst_cmd want;
            if (pending_bursts.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("burst with none expected: %s", describe(got));
                return;
            end
            want = pending_bursts.pop_front();
            if (got.load_page != want.load_page || got.row != want.row ||
                got.col != want.col || got.len != want.len ||
                got.offset != want.offset || got.last != want.last ||
                got.range_err != want.range_err) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("burst mismatch, expected %s", describe(want));
                    $display("                actual   %s", describe(got));
                end
            end
        endfunction
    endclass

endpackage

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import nrrs_pkg::*;
    import nrrs_tb_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 6;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int SETTLE_CYCLES   = 64;
    localparam int ITEMS_PER_PHASE = 17;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic [ACT_W-1:0]     i_action;
    logic [ADDR_W-1:0]    i_byte_address;
    logic [COUNT_W-1:0]   i_byte_count;
    logic [TIDX_W-1:0]    i_table_index;
    logic [TVAL_W-1:0]    i_table_value;
    logic                 o_valid;
    logic                 i_ready;
    logic                 o_load_page;
    logic [ROW_W-1:0]     o_row_address;
    logic [COL_W-1:0]     o_column_address;
    logic [LEN_W-1:0]     o_burst_length;
    logic [OFF_W-1:0]     o_destination_offset;
    logic                 o_last;
    logic                 o_range_error;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    burst_scoreboard  board = new();
    int unsigned      cycle_count = 0;
    logic [CFG_W-1:0] stim_ps_raw = PSL_RST;
    logic [CFG_W-1:0] stim_bs_raw = PBL_RST;
    logic [ADDR_W-1:0] next_read_addr = '0;
    bit               sender_calm = 1'b0;

    nand_read_remap_splitter_core DUT (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_action             (i_action),
        .i_byte_address       (i_byte_address),
        .i_byte_count         (i_byte_count),
        .i_table_index        (i_table_index),
        .i_table_value        (i_table_value),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_load_page          (o_load_page),
        .o_row_address        (o_row_address),
        .o_column_address     (o_column_address),
        .o_burst_length       (o_burst_length),
        .o_destination_offset (o_destination_offset),
        .o_last               (o_last),
        .o_range_error        (o_range_error),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timed out after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Values read here are the ones sampled at this edge.
    always @(posedge i_clk) begin
        t_burst_cmd seen;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                board.write_reg(t_cfg_reg'(i_cfg_index), i_cfg_data);
            if (i_valid && o_ready)
                board.note_word(t_action'(i_action), i_byte_address, i_byte_count,
                                i_table_index, i_table_value);
            if (o_valid && i_ready) begin
                seen.load_page = o_load_page;
                seen.row       = o_row_address;
                seen.col       = o_column_address;
                seen.len       = o_burst_length;
                seen.offset    = o_destination_offset;
                seen.last      = o_last;
                seen.range_err = o_range_error;
                board.check_burst(seen);
            end
        end
    end

    // result side: random stalls, with calm stretches
    initial begin
        int unsigned stall;
        bit          calm;
        i_ready = 1'b0;
        calm    = 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 15) == 0)
                calm = !calm;
            stall = calm ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    task automatic send_word(input t_action act, input logic [ADDR_W-1:0] addr,
                             input logic [COUNT_W-1:0] cnt, input logic [TIDX_W-1:0] tidx,
                             input logic [TVAL_W-1:0] tval);
        int unsigned gap;
        if ($urandom_range(0, 19) == 0)
            sender_calm = !sender_calm;
        gap = sender_calm ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_action       <= act;
        i_byte_address <= addr;
        i_byte_count   <= cnt;
        i_table_index  <= tidx;
        i_table_value  <= tval;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // any other action, with all fields random
    task automatic send_random_fields(input t_action act);
        send_word(act, $urandom(), COUNT_W'($urandom()), TIDX_W'($urandom()),
                  TVAL_W'($urandom()));
    endtask

    task automatic send_read(input logic [ADDR_W-1:0] addr, input logic [COUNT_W-1:0] cnt);
        send_word(ACT_READ, addr, cnt, TIDX_W'($urandom()), TVAL_W'($urandom()));
    endtask

    task automatic hold_for_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (board.outstanding() != 0);
    endtask

    // words that give no burst may still be in the queue once results are in
    task automatic settle();
        hold_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_geometry(input logic [CFG_W-1:0] ps_raw,
                                    input logic [CFG_W-1:0] bs_raw);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_PAGE_SIZE;
        i_cfg_data  <= ps_raw;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_PAGES_PER_BLOCK;
        i_cfg_data  <= bs_raw;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        stim_ps_raw = ps_raw;
        stim_bs_raw = bs_raw;
    endtask

    task automatic send_random_read();
        int unsigned ps, bs, sel, col;
        logic [ADDR_W-1:0]  addr;
        logic [COUNT_W-1:0] cnt;
        board.effective_shifts(stim_ps_raw, stim_bs_raw, ps, bs);
        sel = $urandom_range(0, 2);
        col = (sel == 0) ? 0 :
              (sel == 1) ? $urandom_range(0, (1 << ps) - 1) : (1 << ps) - $urandom_range(1, 16);
        sel = $urandom_range(0, 99);
        if (sel < 25)
            addr = next_read_addr;              // carry on where the last read stopped
        else if (sel < 75)
            addr = ($urandom_range(0, LOGICAL_BLOCKS - 1) << (ps + bs)) |
                   ($urandom_range(0, (1 << bs) - 1) << ps) | col;
        else if (sel < 88)
            addr = (LOGICAL_BLOCKS << (ps + bs)) - $urandom_range(1, 3000);
        else
            addr = $urandom();
        sel = $urandom_range(0, 99);
        if (sel < 4)
            cnt = '0;
        else if (sel < 45)
            cnt = COUNT_W'($urandom_range(1, 300));
        else if (sel < 82)
            cnt = COUNT_W'($urandom_range(1, MAX_COUNT));
        else if (sel < 90)
            cnt = COUNT_W'(MAX_COUNT);
        else
            cnt = COUNT_W'($urandom_range(MAX_COUNT + 1, (1 << COUNT_W) - 1));
        next_read_addr = addr + ((cnt > MAX_COUNT) ? MAX_COUNT : cnt);
        send_read(addr, cnt);
    endtask

    task automatic send_random_item(output bit counted);
        int unsigned sel;
        counted = 1'b1;
        if ($urandom_range(0, 24) == 0)
            hold_for_results();
        sel = $urandom_range(0, 99);
        if (sel < 65)
            send_random_read();
        else if (sel < 80)
            send_random_fields(ACT_TABLE);
        else if (sel < 92)
            send_random_fields(ACT_INVAL);
        else begin
            send_random_fields(ACT_UNUSED);
            counted = 1'b0;
        end
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] ps_raw, input logic [CFG_W-1:0] bs_raw);
        int unsigned done_items;
        bit          counted;
        program_geometry(ps_raw, bs_raw);
        done_items = 0;
        while (done_items < ITEMS_PER_PHASE) begin
            send_random_item(counted);
            if (counted)
                done_items++;
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_action       = ACT_READ;
        i_byte_address = '0;
        i_byte_count   = '0;
        i_table_index  = '0;
        i_table_value  = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_PAGE_SIZE;
        i_cfg_data     = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry: 2 KiB pages, 64 pages a block, table ends at 4 MiB
        send_read(32'h0000_0000, 13'd1);
        send_read(32'h0000_0001, 13'd1);          // same row, no page load
        send_read(32'h0000_0000, 13'd4096);
        send_read(32'h0000_07FF, 13'd4096);       // unaligned, three pages
        send_read(32'h0001_2345, 13'd0);
        send_read(32'h0000_0100, 13'h1FFF);       // count clamps to 4096
        send_word(ACT_TABLE, '0, '0, 5'd1, 12'hFFF);
        send_read(32'h0002_07F0, 13'd300);        // odd physical block: plane bit
        send_word(ACT_TABLE, '1, '1, 5'd31, 12'h000);
        send_read(32'h003E_0000, 13'd512);
        send_word(ACT_TABLE, '0, '0, 5'd2, 12'h555);
        send_read(32'h0004_0000, 13'd64);
        send_read(32'h0004_0040, 13'd64);
        hold_for_results();
        send_word(ACT_INVAL, '1, '1, '1, '1);
        send_read(32'h0004_0080, 13'd64);         // mark cleared, page loads again
        send_read(32'h0040_0000, 13'd16);         // first block past the table
        send_read(32'h003F_FF00, 13'd1000);       // runs off the end of the table
        send_read(32'hFFFF_FFFF, 13'd2);
        send_read(32'hFFFF_FFFF, 13'd0);
        send_random_fields(ACT_UNUSED);
        send_word(ACT_TABLE, '0, '0, 5'd0, 12'hAAA);
        send_read(32'h0000_0010, 13'd10);

        run_phase(4'd9, 4'd4);
        run_phase(4'd13, 4'd8);
        run_phase(4'd0, 4'd0);
        run_phase(4'd15, 4'd15);
        run_phase(4'd10, 4'd5);
        run_phase(4'd12, 4'd7);
        run_phase(4'd11, 4'd6);

        settle();
        if (board.outstanding() != 0)
            $display("%0d expected bursts never arrived", board.outstanding());
        if (board.mismatches == 0 && board.outstanding() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
